@@ rtl/brb_pkg.sv @@
// Shared types and codes for the byte ring buffer.
`default_nettype none
package brb_pkg;

    localparam int CAP_W    = 13;
    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 12;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_CONSUME = 2'd2,
        CMD_CANCEL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_STRAY   = 2'd2
    } t_status;

endpackage
`default_nettype wire

@@ rtl/brb_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/byte_ring_buffer_peek_cancel_unit.sv @@
// Byte ring buffer with write runs, peek, consume and cancel.
// A write, consume or cancel result, or a refused or empty peek, is in the output register
// in the cycle after its request; a peek reads the store, then each byte is registered out
// while the next is read. Write, consume and cancel take one request per cycle, and a peek
// streams a byte a cycle, while the output is not stalled; the input stalls through a peek.
// Reset (synchronous, active low) empties the buffer, drops any open run and sets capacity
// to DEPTH, at most CAP_MAX; store contents are not cleared, since only written bytes are read.
`default_nettype none
module byte_ring_buffer_peek_cancel_unit #(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [brb_pkg::CAP_W-1:0]       i_cfg_wdata,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_command,
    input  wire logic [brb_pkg::DATA_W-1:0]      i_data_byte,
    input  wire logic                            i_run_start,
    input  wire logic [brb_pkg::CAP_W-1:0]       i_count,
    input  wire logic [brb_pkg::OFFSET_W-1:0]    i_peek_offset,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_status,
    output logic [brb_pkg::DATA_W-1:0]           o_read_byte,
    output logic                                 o_last,
    output logic [brb_pkg::CAP_W-1:0]            o_used_bytes,
    output logic [brb_pkg::CAP_W-1:0]            o_free_bytes
);

    localparam int CAP_W   = brb_pkg::CAP_W;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam int RW      = $clog2(MAX_READ + 1);
    localparam int CAP_LIM = (1 << CAP_W) - 1;
    localparam int CAP_MAX = (DEPTH > CAP_LIM) ? CAP_LIM : DEPTH;

    typedef enum logic {
        S_IDLE,
        S_PEEK
    } t_state;

    t_state                      r_state, n_state;
    logic [CAP_W-1:0]            r_cap, n_cap;
    logic [AW-1:0]               r_oldest, n_oldest;
    logic [CAP_W-1:0]            r_used, n_used;
    logic                        r_run_open, n_run_open;
    logic                        r_run_refused, n_run_refused;
    logic [AW-1:0]               r_run_wp, n_run_wp;
    logic [CAP_W-1:0]            r_run_rem, n_run_rem;
    logic [CAP_W-1:0]            r_run_total, n_run_total;
    logic [AW-1:0]               r_peek_ptr, n_peek_ptr;
    logic [RW-1:0]               r_peek_rem, n_peek_rem;

    logic                        r_o_valid, n_o_valid;
    brb_pkg::t_status            r_o_status, n_o_status;
    logic [brb_pkg::DATA_W-1:0]  r_o_byte, n_o_byte;
    logic                        r_o_last, n_o_last;
    logic [CAP_W-1:0]            r_o_used, n_o_used;
    logic [CAP_W-1:0]            r_o_free, n_o_free;

    logic                        out_free;
    logic                        in_acc;
    brb_pkg::t_cmd               cmd;
    logic                        drop_run;
    logic [CAP_W-1:0]            free_now;
    logic [AW-1:0]               tail;
    logic [AW-1:0]               peek_first;
    logic [CAP_W:0]              peek_sum;
    logic                        peek_bad;
    logic                        peek_go;
    logic [CAP_W-1:0]            cfg_cap;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic [brb_pkg::DATA_W-1:0]  w_rdata;

    // wrap a pointer sum that is below twice the capacity
    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] p,
                                             input logic [CAP_W-1:0] cap);
        logic [SW-1:0] c;
        c = SW'(cap);
        f_wrap = (p >= c) ? AW'(p - c) : AW'(p);
    endfunction

    brb_ram #(
        .WIDTH (brb_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign cmd        = brb_pkg::t_cmd'(i_command);
    assign drop_run   = (cmd != brb_pkg::CMD_WRITE) || i_run_start;
    assign free_now   = r_cap - r_used;
    assign tail       = f_wrap(SW'(r_oldest) + SW'(r_used), r_cap);
    assign peek_first = f_wrap(SW'(r_oldest) + SW'(i_peek_offset), r_cap);
    assign peek_sum   = {1'b0, i_count} + (CAP_W + 1)'(i_peek_offset);
    assign peek_bad   = (i_count > CAP_W'(MAX_READ)) || (peek_sum > (CAP_W + 1)'(r_used));
    assign peek_go    = (cmd == brb_pkg::CMD_PEEK) && !peek_bad && (i_count != '0);

    // clamp capacity into 1..CAP_MAX
    assign cfg_cap = (i_cfg_wdata == '0) ? CAP_W'(1) :
                     ((32'(i_cfg_wdata) > 32'(CAP_MAX)) ? CAP_W'(CAP_MAX) : i_cfg_wdata);

    always_comb begin
        n_state       = r_state;
        n_cap         = r_cap;
        n_oldest      = r_oldest;
        n_used        = r_used;
        n_run_open    = r_run_open;
        n_run_refused = r_run_refused;
        n_run_wp      = r_run_wp;
        n_run_rem     = r_run_rem;
        n_run_total   = r_run_total;
        n_peek_ptr    = r_peek_ptr;
        n_peek_rem    = r_peek_rem;
        n_o_valid     = r_o_valid && i_out_stall;
        n_o_status    = r_o_status;
        n_o_byte      = r_o_byte;
        n_o_last      = r_o_last;
        n_o_used      = r_o_used;
        n_o_free      = r_o_free;
        w_we          = 1'b0;
        w_waddr       = r_run_wp;
        w_re          = 1'b0;
        w_raddr       = peek_first;

        if (i_cfg_we) begin
            n_cap         = cfg_cap;
            n_oldest      = '0;
            n_used        = '0;
            n_run_wp      = '0;
            n_run_total   = '0;
            n_run_open    = 1'b0;
            n_run_refused = 1'b0;
            n_run_rem     = '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (drop_run) begin
                            n_run_open    = 1'b0;
                            n_run_refused = 1'b0;
                            n_run_rem     = '0;
                        end
                        n_o_status = brb_pkg::ST_OK;
                        unique case (cmd)
                            brb_pkg::CMD_WRITE: begin
                                if (i_run_start) begin
                                    n_run_total = i_count;
                                    if (i_count == '0) begin
                                        n_o_status = brb_pkg::ST_OK;
                                    end else if (i_count > free_now) begin
                                        // swallow the rest of the run
                                        n_run_rem     = i_count - 1'b1;
                                        n_run_open    = (i_count != CAP_W'(1));
                                        n_run_refused = (i_count != CAP_W'(1));
                                        n_o_status    = brb_pkg::ST_REFUSED;
                                    end else begin
                                        w_we      = 1'b1;
                                        w_waddr   = tail;
                                        n_run_wp  = f_wrap(SW'(tail) + SW'(1), r_cap);
                                        n_run_rem = i_count - 1'b1;
                                        if (i_count == CAP_W'(1)) begin
                                            n_used = r_used + i_count;
                                        end else begin
                                            n_run_open = 1'b1;
                                        end
                                    end
                                end else if (!r_run_open) begin
                                    n_o_status = brb_pkg::ST_STRAY;
                                end else if (r_run_refused) begin
                                    n_run_rem  = r_run_rem - 1'b1;
                                    n_o_status = brb_pkg::ST_REFUSED;
                                    if (r_run_rem == CAP_W'(1)) begin
                                        n_run_open    = 1'b0;
                                        n_run_refused = 1'b0;
                                    end
                                end else begin
                                    w_we      = 1'b1;
                                    w_waddr   = r_run_wp;
                                    n_run_wp  = f_wrap(SW'(r_run_wp) + SW'(1), r_cap);
                                    n_run_rem = r_run_rem - 1'b1;
                                    // commit the run on its final byte
                                    if (r_run_rem == CAP_W'(1)) begin
                                        n_used     = r_used + r_run_total;
                                        n_run_open = 1'b0;
                                    end
                                end
                            end
                            brb_pkg::CMD_PEEK: begin
                                if (peek_bad) begin
                                    n_o_status = brb_pkg::ST_REFUSED;
                                end else if (peek_go) begin
                                    w_re       = 1'b1;
                                    w_raddr    = peek_first;
                                    n_peek_ptr = peek_first;
                                    n_peek_rem = i_count[RW-1:0];
                                    n_state    = S_PEEK;
                                end
                            end
                            brb_pkg::CMD_CONSUME: begin
                                if (i_count > r_used) begin
                                    n_o_status = brb_pkg::ST_REFUSED;
                                end else begin
                                    n_oldest = f_wrap(SW'(r_oldest) + SW'(i_count), r_cap);
                                    n_used   = r_used - i_count;
                                end
                            end
                            brb_pkg::CMD_CANCEL: begin
                                if (i_count > r_used) begin
                                    n_o_status = brb_pkg::ST_REFUSED;
                                end else begin
                                    n_used = r_used - i_count;
                                end
                            end
                            default: begin
                                n_o_status = brb_pkg::ST_OK;
                            end
                        endcase
                        if (!peek_go) begin
                            n_o_valid = 1'b1;
                            n_o_byte  = '0;
                            n_o_last  = 1'b1;
                            n_o_used  = n_used;
                            n_o_free  = n_cap - n_used;
                        end
                    end
                end
                S_PEEK: begin
                    if (out_free) begin
                        n_o_valid  = 1'b1;
                        n_o_status = brb_pkg::ST_OK;
                        n_o_byte   = w_rdata;
                        n_o_last   = (r_peek_rem == RW'(1));
                        n_o_used   = r_used;
                        n_o_free   = r_cap - r_used;
                        if (r_peek_rem == RW'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            // fetch the next byte while this one goes out
                            n_peek_ptr = f_wrap(SW'(r_peek_ptr) + SW'(1), r_cap);
                            n_peek_rem = r_peek_rem - 1'b1;
                            w_re       = 1'b1;
                            w_raddr    = n_peek_ptr;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cap         <= CAP_W'(CAP_MAX);
            r_oldest      <= '0;
            r_used        <= '0;
            r_run_open    <= 1'b0;
            r_run_refused <= 1'b0;
            r_run_wp      <= '0;
            r_run_rem     <= '0;
            r_run_total   <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cap         <= n_cap;
            r_oldest      <= n_oldest;
            r_used        <= n_used;
            r_run_open    <= n_run_open;
            r_run_refused <= n_run_refused;
            r_run_wp      <= n_run_wp;
            r_run_rem     <= n_run_rem;
            r_run_total   <= n_run_total;
            r_o_valid     <= n_o_valid;
        end
        r_peek_ptr <= n_peek_ptr;
        r_peek_rem <= n_peek_rem;
        r_o_status <= n_o_status;
        r_o_byte   <= n_o_byte;
        r_o_last   <= n_o_last;
        r_o_used   <= n_o_used;
        r_o_free   <= n_o_free;
    end

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_read_byte  = r_o_byte;
    assign o_last       = r_o_last;
    assign o_used_bytes = r_o_used;
    assign o_free_bytes = r_o_free;

    a_used_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_cap)
        else $error("used count exceeds capacity");

    a_oldest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_oldest) < SW'(r_cap))
        else $error("oldest pointer outside capacity");

    a_run_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_open && !r_run_refused) |-> (SW'(r_run_wp) < SW'(r_cap)))
        else $error("run write pointer outside capacity");

    a_peek_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_we && peek_go) |=> (r_state == S_PEEK))
        else $error("accepted peek did not start streaming");

    a_peek_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEEK && n_state == S_IDLE && !i_cfg_we) |=> (r_o_valid && r_o_last))
        else $error("peek finished without a final result");

endmodule
`default_nettype wire
